@@ sv/mfw_pkg.sv @@
// Shared types and constants of the median filter window unit.
package mfw_pkg;

    localparam int PIX_W          = 8;
    localparam int KSIZE_DEF      = 3;
    localparam int MAX_WIDTH_DEF  = 1024;

    // configuration port
    localparam int CFG_W_W        = 11;
    localparam int CFG_H_W        = 12;
    localparam int CFG_DATA_W     = 12;
    localparam int CFG_ADDR_W     = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
    localparam int IMAGE_WIDTH_RST  = 300;
    localparam int IMAGE_HEIGHT_RST = 300;

    // request kinds carried in tuser
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // room for a position plus the window edge
    localparam int CMP_W = 13;

    // per-item decision taken at the input transfer
    typedef struct packed {
        logic pix;
        logic emit;
        logic border;
        logic last;
    } t_ctl;

    // side data that travels with a window through the sorter
    typedef struct packed {
        logic             border;
        logic             last;
        logic [PIX_W-1:0] center;
    } t_side;

endpackage

@@ sv/mfw_ctrl.sv @@
// Frame geometry registers, raster position counters and the pending-pixel queue.
module mfw_ctrl #(
    parameter int KSIZE     = mfw_pkg::KSIZE_DEF,
    parameter int MAX_WIDTH = mfw_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mfw_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [mfw_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_acc,
    input  logic                            i_req,
    input  logic [mfw_pkg::PIX_W-1:0]       i_pixel,
    output mfw_pkg::t_ctl                   o_ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]    o_col,
    output logic [mfw_pkg::PIX_W-1:0]       o_center
);
    import mfw_pkg::*;

    localparam int EDGE      = KSIZE / 2;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int DLY_MAX   = EDGE * MAX_WIDTH + EDGE;
    localparam int PEND_W    = $clog2(DLY_MAX + 2);
    localparam int FA_W      = $clog2(DLY_MAX + 1);
    localparam int FDEPTH    = 1 << FA_W;
    localparam int W_RST_EFF = (IMAGE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RST;

    logic [CFG_W_W-1:0]  r_w;
    logic [CFG_H_W-1:0]  r_h;
    logic [PEND_W-1:0]   r_dly;
    logic [CFG_W_W-1:0]  n_w;
    logic [CFG_H_W-1:0]  n_h;

    logic [COL_W-1:0]    r_in_col, n_in_col, r_out_col, n_out_col;
    logic [CFG_H_W-1:0]  r_in_row, n_in_row, r_out_row, n_out_row;
    logic [PEND_W-1:0]   r_pend, n_pend, pend_inc;
    logic [FA_W-1:0]     r_wp, r_rp;
    logic [PIX_W-1:0]    r_fifo [FDEPTH];
    logic [PIX_W-1:0]    r_center;

    logic is_pix, is_drain, emit, border, last;
    logic in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;

    // clamp the geometry as it is written
    always_comb begin
        if (i_cfg_wdata[CFG_W_W-1:0] == '0) begin
            n_w = CFG_W_W'(1);
        end else if (CMP_W'(i_cfg_wdata[CFG_W_W-1:0]) > CMP_W'(MAX_WIDTH)) begin
            n_w = CFG_W_W'(MAX_WIDTH);
        end else begin
            n_w = i_cfg_wdata[CFG_W_W-1:0];
        end
        if (i_cfg_wdata[CFG_H_W-1:0] == '0) begin
            n_h = CFG_H_W'(1);
        end else begin
            n_h = i_cfg_wdata[CFG_H_W-1:0];
        end
    end

    always_comb begin
        is_pix   = (i_req == REQ_PIXEL);
        is_drain = (i_req == REQ_DRAIN);
        pend_inc = r_pend + PEND_W'(1);
        if (is_pix) begin
            emit = (pend_inc > r_dly);
        end else begin
            emit = is_drain && (r_in_row == '0) && (r_in_col == '0) && (r_pend != '0);
        end

        in_col_wrap  = (CMP_W'(r_in_col) + CMP_W'(1)) >= CMP_W'(r_w);
        in_row_wrap  = (CMP_W'(r_in_row) + CMP_W'(1)) >= CMP_W'(r_h);
        out_col_wrap = (CMP_W'(r_out_col) + CMP_W'(1)) >= CMP_W'(r_w);
        out_row_wrap = (CMP_W'(r_out_row) + CMP_W'(1)) >= CMP_W'(r_h);

        border = (CMP_W'(r_out_row) < CMP_W'(EDGE)) ||
                 (CMP_W'(r_out_row) + CMP_W'(EDGE) >= CMP_W'(r_h)) ||
                 (CMP_W'(r_out_col) < CMP_W'(EDGE)) ||
                 (CMP_W'(r_out_col) + CMP_W'(EDGE) >= CMP_W'(r_w));
        last   = (CMP_W'(r_out_row) + CMP_W'(1) == CMP_W'(r_h)) &&
                 (CMP_W'(r_out_col) + CMP_W'(1) == CMP_W'(r_w));

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_pend    = r_pend;

        if (is_pix) begin
            if (in_col_wrap) begin
                n_in_col = '0;
                n_in_row = in_row_wrap ? '0 : r_in_row + CFG_H_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
        end
        if (emit) begin
            if (out_col_wrap) begin
                n_out_col = '0;
                n_out_row = out_row_wrap ? '0 : r_out_row + CFG_H_W'(1);
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
        end
        if (is_pix && !emit) begin
            n_pend = pend_inc;
        end else if (!is_pix && emit) begin
            n_pend = r_pend - PEND_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= CFG_W_W'(W_RST_EFF);
            r_h       <= CFG_H_W'(IMAGE_HEIGHT_RST);
            r_dly     <= PEND_W'(EDGE * W_RST_EFF + EDGE);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pend    <= '0;
            r_wp      <= '0;
            r_rp      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_IMAGE_WIDTH: begin
                        r_w   <= n_w;
                        r_dly <= PEND_W'(EDGE * int'(n_w) + EDGE);
                    end
                    REG_IMAGE_HEIGHT: begin
                        r_h <= n_h;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_acc) begin
                r_in_col  <= n_in_col;
                r_in_row  <= n_in_row;
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
                r_pend    <= n_pend;
                if (is_pix) begin
                    r_wp <= r_wp + FA_W'(1);
                end
                if (emit) begin
                    r_rp <= r_rp + FA_W'(1);
                end
            end
        end
    end

    // pending pixels in arrival order; the head is the pixel that goes out next
    always_ff @(posedge i_clk) begin
        if (i_acc && is_pix) begin
            r_fifo[r_wp] <= i_pixel;
        end
        if (i_acc && emit) begin
            r_center <= r_fifo[r_rp];
        end
    end

    always_comb begin
        o_ctl.pix    = is_pix;
        o_ctl.emit   = emit;
        o_ctl.border = border;
        o_ctl.last   = last;
    end

    assign o_col    = r_in_col;
    assign o_center = r_center;

endmodule

@@ sv/mfw_window.sv @@
// Line memories and the KSIZE x KSIZE window registers.
module mfw_window #(
    parameter int KSIZE     = mfw_pkg::KSIZE_DEF,
    parameter int MAX_WIDTH = mfw_pkg::MAX_WIDTH_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_load,
    input  logic [$clog2(MAX_WIDTH)-1:0]                  i_col,
    input  logic [mfw_pkg::PIX_W-1:0]                     i_pixel,
    input  logic                                          i_s1_pix,
    input  logic                                          i_adv,
    output logic [KSIZE*KSIZE-1:0][mfw_pkg::PIX_W-1:0]    o_win
);
    import mfw_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int NL    = KSIZE - 1;

    logic [PIX_W-1:0]                      r_mem [NL][MAX_WIDTH];
    logic [NL-1:0][PIX_W-1:0]              r_q;
    logic [NL-1:0][PIX_W-1:0]              r_byp_data;
    logic                                  r_byp;
    logic [PIX_W-1:0]                      r_px;
    logic [COL_W-1:0]                      r_col;
    logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] r_win;

    logic [NL-1:0][PIX_W-1:0]              s1_rd;
    logic [NL-1:0][PIX_W-1:0]              wr_data;
    logic [KSIZE-1:0][PIX_W-1:0]           row_in;
    logic                                  wr_en;
    logic                                  hit;

    // line k holds the pixels (k+1) lines back
    assign s1_rd = r_byp ? r_byp_data : r_q;
    assign wr_en = i_s1_pix && i_adv;
    // the pixel just ahead sits at the same column only on a one-pixel line
    assign hit   = wr_en && (r_col == i_col);

    always_comb begin
        wr_data[0] = r_px;
        for (int k = 1; k < NL; k++) begin
            wr_data[k] = s1_rd[k-1];
        end
        row_in[0] = r_px;
        for (int j = 1; j < KSIZE; j++) begin
            row_in[j] = s1_rd[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NL; k++) begin
            if (wr_en) begin
                r_mem[k][r_col] <= wr_data[k];
            end
            if (i_load) begin
                r_q[k] <= r_mem[k][i_col];
            end
        end
        if (i_load) begin
            r_byp      <= hit;
            r_byp_data <= wr_data;
            r_px       <= i_pixel;
            r_col      <= i_col;
        end
    end

    // column 0 holds the newest pixel of each row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (wr_en) begin
            for (int j = 0; j < KSIZE; j++) begin
                r_win[j] <= {r_win[j][KSIZE-2:0], row_in[j]};
            end
        end
    end

    assign o_win = r_win;

endmodule

@@ sv/mfw_median.sv @@
// Pipelined odd-even transposition sorter with output register.
module mfw_median #(
    parameter int KSIZE = mfw_pkg::KSIZE_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic [KSIZE*KSIZE-1:0][mfw_pkg::PIX_W-1:0]    i_win,
    input  mfw_pkg::t_side                                i_side,
    output logic                                          o_valid,
    input  logic                                          i_ready,
    output logic [mfw_pkg::PIX_W-1:0]                     o_pixel,
    output logic                                          o_last
);
    import mfw_pkg::*;

    localparam int N   = KSIZE * KSIZE;
    localparam int NS  = (N + 1) / 2;
    localparam int MID = N / 2;

    typedef logic [N-1:0][PIX_W-1:0] t_vec;

    t_vec             r_vec  [NS];
    t_side            r_side [NS];
    logic [NS-1:0]    r_v;
    logic             r_ov;
    logic [PIX_W-1:0] r_pixel;
    logic             r_last;
    logic             en;

    // one even and one odd compare-exchange phase
    function automatic t_vec cx2(input t_vec a);
        t_vec b;
        t_vec c;
        b = a;
        for (int p = 0; p + 1 < N; p += 2) begin
            if (a[p] > a[p+1]) begin
                b[p]   = a[p+1];
                b[p+1] = a[p];
            end
        end
        c = b;
        for (int p = 1; p + 1 < N; p += 2) begin
            if (b[p] > b[p+1]) begin
                c[p]   = b[p+1];
                c[p+1] = b[p];
            end
        end
        return c;
    endfunction

    // hold the whole sorter while a result waits
    assign en      = !r_ov || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v  <= {r_v[NS-2:0], i_valid};
            r_ov <= r_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vec[0]  <= cx2(i_win);
            r_side[0] <= i_side;
            for (int s = 1; s < NS; s++) begin
                r_vec[s]  <= cx2(r_vec[s-1]);
                r_side[s] <= r_side[s-1];
            end
            r_pixel <= r_side[NS-1].border ? r_side[NS-1].center : r_vec[NS-1][MID];
            r_last  <= r_side[NS-1].last;
        end
    end

    assign o_valid = r_ov;
    assign o_pixel = r_pixel;
    assign o_last  = r_last;

endmodule

@@ sv/median_filter_window_unit.sv @@
// Top level of the streaming KSIZE x KSIZE median filter.
//
// Input stream: one item per transfer, tuser = request kind (pixel or drain),
// tdata = grey pixel in raster order. Output stream: one filtered pixel per
// transfer in raster order, tlast marks the last pixel of the frame.
// Frame width and height come from the write port (index 0 width, 1 height);
// write them only while no item is in flight.
// A pixel leaves edge*width+edge input pixels after it came in (edge =
// KSIZE/2); drain items sent after a frame push the remaining pixels out, one
// per drain, and a drain with nothing pending gives nothing.
// Pipeline: input stage (line memory and queue reads), window stage, then
// (KSIZE*KSIZE+1)/2 sorter stages of two compare-exchange phases each, then the
// output register. Throughput is one item per cycle while the receiver does not
// stall, set by the single read and write port of each line memory and of the
// pending-pixel queue.
// Reset clears geometry to 300x300, all counters and all valid bits; line
// memories are not cleared. When the receiver stalls, the sorter and output
// register hold; the two front stages keep taking items until they fill.
module median_filter_window_unit #(
    parameter int KSIZE     = mfw_pkg::KSIZE_DEF,
    parameter int MAX_WIDTH = mfw_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mfw_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [mfw_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [mfw_pkg::PIX_W-1:0]       i_s_axis_tdata,   // [7:0] pixel_in
    input  logic                            i_s_axis_tuser,   // [0] req_type
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [mfw_pkg::PIX_W-1:0]       o_m_axis_tdata,   // [7:0] pixel_out
    output logic                            o_m_axis_tlast
);
    import mfw_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    t_ctl                            ctl;
    logic [COL_W-1:0]                col;
    logic [PIX_W-1:0]                center;
    logic [KSIZE*KSIZE-1:0][PIX_W-1:0] win;
    t_side                           side;

    logic       r_s1_v, r_s2_v;
    t_ctl       r_s1_ctl, r_s2_ctl;
    logic [PIX_W-1:0] r_s2_center;
    logic       take1, take2, adv1, acc, sort_ready;

    // items that make no result leave after the window stage
    assign take2 = !r_s2_v || !r_s2_ctl.emit || sort_ready;
    assign take1 = !r_s1_v || take2;
    assign adv1  = r_s1_v && take2;
    assign acc   = i_s_axis_tvalid && take1;
    assign o_s_axis_tready = take1;

    mfw_ctrl #(
        .KSIZE     (KSIZE),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_acc       (acc),
        .i_req       (i_s_axis_tuser),
        .i_pixel     (i_s_axis_tdata),
        .o_ctl       (ctl),
        .o_col       (col),
        .o_center    (center)
    );

    mfw_window #(
        .KSIZE     (KSIZE),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (acc && ctl.pix),
        .i_col    (col),
        .i_pixel  (i_s_axis_tdata),
        .i_s1_pix (r_s1_v && r_s1_ctl.pix),
        .i_adv    (adv1),
        .o_win    (win)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (take1) begin
                r_s1_v <= acc;
            end
            if (take2) begin
                r_s2_v <= adv1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_ctl <= ctl;
        end
        if (adv1) begin
            r_s2_ctl    <= r_s1_ctl;
            r_s2_center <= center;
        end
    end

    always_comb begin
        side.border = r_s2_ctl.border;
        side.last   = r_s2_ctl.last;
        side.center = r_s2_center;
    end

    mfw_median #(
        .KSIZE (KSIZE)
    ) u_median (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_v && r_s2_ctl.emit),
        .o_ready (sort_ready),
        .i_win   (win),
        .i_side  (side),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_pixel (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule

@@ sv/mfw_checker.sv @@
// Port-level checks of the median filter window unit and their binding.
module mfw_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_s_axis_tready,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [mfw_pkg::PIX_W-1:0] o_m_axis_tdata,
    input logic                      o_m_axis_tlast
);
    import mfw_pkg::*;

    // a stalled result keeps its pixel and frame marker
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output transfer changed while stalled");

    // the pipeline is deeper than two stages, so nothing comes out right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid ##1 !o_m_axis_tvalid)
        else $error("output valid too soon after reset");

    // an empty pipeline takes input
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind median_filter_window_unit mfw_checker u_mfw_checker (.*);
